// ===== hdl/dts_pkg.sv =====
// Shared types, character codes and byte classification for the delimited tag scanner.
package dts_pkg;

   localparam int POS_WIDTH = 24;

   typedef logic [POS_WIDTH-1:0] pos_type;
   typedef logic [1:0]           mode_type;

   localparam pos_type POS_MAX = '1;

   localparam mode_type FILTER_ALL = 2'd0;
   localparam mode_type FILTER_ENC = 2'd1;
   localparam mode_type FILTER_RAW = 2'd2;

   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CHAR_L     = 8'h4C;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_Q     = 8'h51;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;

   localparam pos_type ENC_MIN_LEN = pos_type'(4);

   typedef struct packed {
      logic [7:0] text_byte;
      logic       first_of_text;
   } req_type;

   typedef struct packed {
      pos_type start_pos;
      pos_type end_pos;
      pos_type payload_len;
      logic    is_encrypted;
   } rsp_type;

   function automatic logic is_b64(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CHAR_PLUS || c == CHAR_SLASH ||
             c == CHAR_EQUAL;
   endfunction

   // Does byte c fit the encrypted form at payload index idx.
   function automatic logic byte_fits(input logic [7:0] c, input pos_type idx);
      logic fits;
      if (idx == pos_type'(0)) begin
         fits = (c == CHAR_L) || (c == CHAR_O) || (c == CHAR_Q);
      end else if (idx == pos_type'(1)) begin
         fits = (c == CHAR_ONE);
      end else if (idx == pos_type'(2)) begin
         fits = (c == CHAR_COLON);
      end else begin
         fits = is_b64(c);
      end
      return fits;
   endfunction

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? POS_MAX : v + pos_type'(1);
   endfunction

endpackage

// ===== hdl/dts_scan_core.sv =====
// Scanner state and per-byte update: tag open/close tracking and classification.
module dts_scan_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  dts_pkg::req_type  item,
   input  dts_pkg::mode_type filter_mode,
   output logic              emit,
   output dts_pkg::rsp_type  result
);

   logic             inside_ff, inside_in;
   logic             prev_ff, prev_in;
   logic             held_ff, held_in;
   logic             ok_ff, ok_in;
   dts_pkg::pos_type pos_ff, pos_in;
   dts_pkg::pos_type open_ff, open_in;
   dts_pkg::pos_type count_ff, count_in;

   logic             cur_inside, cur_prev, cur_held, cur_ok;
   dts_pkg::pos_type cur_pos, cur_open, cur_count;
   logic             is_caret, enc, pass;
   dts_pkg::pos_type count_inc2;

   always_comb begin
      // a new text restarts the scan at position zero
      if (item.first_of_text) begin
         cur_inside = 1'b0;
         cur_prev   = 1'b0;
         cur_held   = 1'b0;
         cur_ok     = 1'b1;
         cur_pos    = '0;
         cur_open   = '0;
         cur_count  = '0;
      end else begin
         cur_inside = inside_ff;
         cur_prev   = prev_ff;
         cur_held   = held_ff;
         cur_ok     = ok_ff;
         cur_pos    = pos_ff;
         cur_open   = open_ff;
         cur_count  = count_ff;
      end

      is_caret   = (item.text_byte == dts_pkg::CHAR_CARET);
      enc        = cur_ok && (cur_count >= dts_pkg::ENC_MIN_LEN);
      count_inc2 = (cur_count >= dts_pkg::pos_type'(dts_pkg::POS_MAX - 1)) ?
                   dts_pkg::POS_MAX : cur_count + dts_pkg::pos_type'(2);

      case (filter_mode)
         dts_pkg::FILTER_ENC: pass = enc;
         dts_pkg::FILTER_RAW: pass = !enc;
         default:             pass = 1'b1;
      endcase

      inside_in = cur_inside;
      prev_in   = cur_prev;
      held_in   = cur_held;
      ok_in     = cur_ok;
      open_in   = cur_open;
      count_in  = cur_count;
      pos_in    = dts_pkg::sat_inc(cur_pos);
      emit      = 1'b0;

      if (!cur_inside) begin
         if (is_caret) begin
            if (cur_prev) begin
               inside_in = 1'b1;
               prev_in   = 1'b0;
               held_in   = 1'b0;
               open_in   = (cur_pos != '0) ? cur_pos - dts_pkg::pos_type'(1) : '0;
               count_in  = '0;
               ok_in     = 1'b1;
            end else begin
               prev_in = 1'b1;
            end
         end else begin
            prev_in = 1'b0;
         end
      end else if (cur_held && is_caret) begin
         emit      = (cur_count != '0) && pass;
         inside_in = 1'b0;
         held_in   = 1'b0;
         prev_in   = 1'b0;
         count_in  = '0;
         ok_in     = 1'b1;
      end else if (is_caret) begin
         held_in = 1'b1;
      end else begin
         // a held caret joins the payload first; a caret never fits the form
         held_in  = 1'b0;
         ok_in    = cur_ok && !cur_held && dts_pkg::byte_fits(item.text_byte, cur_count);
         count_in = cur_held ? count_inc2 : dts_pkg::sat_inc(cur_count);
      end

      result.start_pos    = cur_open;
      result.end_pos      = pos_in;
      result.payload_len  = cur_count;
      result.is_encrypted = enc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         prev_ff   <= 1'b0;
         held_ff   <= 1'b0;
         ok_ff     <= 1'b1;
         pos_ff    <= '0;
         open_ff   <= '0;
         count_ff  <= '0;
      end else if (step) begin
         inside_ff <= inside_in;
         prev_ff   <= prev_in;
         held_ff   <= held_in;
         ok_ff     <= ok_in;
         pos_ff    <= pos_in;
         open_ff   <= open_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/delimited_tag_scanner_top.sv =====
// Top level: input register, scanner core, result register and filter mode register.
// An accepted item is held in the input register, and its result is registered in the result register for rsp_valid.
// Throughput: one byte per cycle unless the result register stalls; the scanner core updates its state once per byte.
// A stalled result register holds the input register, which then holds req_ready low.
// Reset (synchronous, active high) empties both registers, clears the scanner state
// and sets the filter mode to emit all tags.
module delimited_tag_scanner_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dts_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dts_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  dts_pkg::mode_type csr_wr_data
);

   dts_pkg::mode_type filter_mode_ff;
   logic              s1_valid_ff;
   dts_pkg::req_type  s1_item_ff;
   logic              rsp_valid_ff;
   dts_pkg::rsp_type  rsp_data_ff;

   logic              advance;
   logic              emit;
   dts_pkg::rsp_type  result;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dts_scan_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (s1_item_ff),
      .filter_mode (filter_mode_ff),
      .emit        (emit),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= dts_pkg::FILTER_ALL;
      end else if (csr_wr_en) begin
         filter_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.payload_len != '0))
      else $error("tag result with empty payload");

   a_end_after_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.end_pos > rsp_data_ff.start_pos))
      else $error("tag end not past its start");

   a_enc_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_encrypted) |->
         (rsp_data_ff.payload_len >= dts_pkg::ENC_MIN_LEN))
      else $error("encrypted tag shorter than minimum");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("input register lost an item while stalled");

endmodule
